FILE: hw/rtl/terminal_line_editor_unit_defines.svh
// ---------------------------------------------------------------------------
// Terminal line editor - assertion macros
// Shared property wrappers for the checker that watches the top level.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_LINE_EDITOR_UNIT_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_UNIT_DEFINES_SVH

// Assertion sampled on clk_i, off while reset is held.
`define TLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on clk_i, also checked during reset.
`define TLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/tle_pkg.sv
// ---------------------------------------------------------------------------
// Terminal line editor package
// Types and byte codes shared by the front decoder, queue and edit engine.
// ---------------------------------------------------------------------------
package tle_pkg;

  // Escape decoder mode
  typedef enum logic [2:0] {
    ESC_PLAIN,
    ESC_SEEN,
    ESC_CSI,
    ESC_CSI_MOD,
    ESC_SS3
  } esc_mode_e;

  // Edit commands handed from front to back
  typedef enum logic [3:0] {
    OP_INSERT,
    OP_RIGHT,
    OP_LEFT,
    OP_WRIGHT,
    OP_WLEFT,
    OP_HOME,
    OP_END,
    OP_BKSP,
    OP_DELETE,
    OP_ENTER,
    OP_CANCEL
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
  } cmd_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ECHO,
    KIND_LINE,
    KIND_FINISH,
    KIND_CANCEL
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [3:0] len;
  } res_t;

  // Edit engine sequencer phases
  typedef enum logic [3:0] {
    PH_START,
    PH_SHIFT,
    PH_ECHO,
    PH_BACK,
    PH_WORD,
    PH_DEL,
    PH_DSHIFT,
    PH_DECHO,
    PH_RUB1,
    PH_RUB2,
    PH_LF,
    PH_LINE,
    PH_CEE,
    PH_CANCEL,
    PH_DONE
  } phase_e;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] MAX_CHARS_RST = 4'd15;
  localparam logic [7:0] NUM_SAT       = 8'd255;

  localparam logic [7:0] BYTE_CTRLC  = 8'h03;
  localparam logic [7:0] BYTE_BEL    = 8'h07;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_SP     = 8'h20;
  localparam logic [7:0] BYTE_DEL    = 8'h7F;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_O        = 8'h4F;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_TILDE    = 8'h7E;

endpackage

FILE: hw/rtl/terminal_line_editor_unit.sv
// ---------------------------------------------------------------------------
// Terminal line editor unit - top level
// Escape decoding front end, command queue and line edit engine.
// ---------------------------------------------------------------------------
// Each key byte is taken by the front decoder while the queue is not full
// and, when it forms an edit key, queued as a command (two entries). The
// edit engine runs one command at a time with one line-store access per
// cycle while the output is not stalled; an insert or delete in the
// middle of the line also shifts the following characters one by one.
// Results leave through an output register and are held while out_stall_i
// is high. The user must write max_chars only while the block is idle;
// the block itself does not enforce this. cfg_ready_o is always high.
module terminal_line_editor_unit #(
  parameter int unsigned LINE_CAPACITY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [3:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] key_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [3:0] line_length_o,
  output logic       last_o
);
  import tle_pkg::*;

  logic [3:0] max_chars_r_q;
  logic       q_push, q_full, q_pop, q_valid;
  cmd_t       push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_r_q <= MAX_CHARS_RST;
    end else begin
      if (cfg_valid_i && cfg_ready_o) max_chars_r_q <= cfg_data_i;
    end
  end

  tle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .key_byte_i (key_byte_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  tle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (pop_cmd)
  );

  tle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_chars_i   (max_chars_r_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (pop_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .out_byte_o    (out_byte_o),
    .line_length_o (line_length_o),
    .last_o        (last_o)
  );

endmodule

FILE: hw/rtl/tle_front.sv
// ---------------------------------------------------------------------------
// Terminal line editor - front decoder
// Accepts key bytes, tracks escape sequences and pushes edit commands.
// ---------------------------------------------------------------------------
module tle_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    key_byte_i,
  output logic          in_stall_o,
  input  logic          q_full_i,
  output logic          q_push_o,
  output tle_pkg::cmd_t q_cmd_o
);
  import tle_pkg::*;

  esc_mode_e  mode_q, mode_d;
  logic [7:0] num_q, num_d;
  logic       mod_q, mod_d;
  logic       accept;
  logic       has_op;
  op_e        op;
  logic [11:0] num_next;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // decimal accumulate, saturating
  assign num_next = {1'b0, num_q, 3'b000} + {3'b000, num_q, 1'b0}
                  + {4'b0000, key_byte_i - CH_0};

  // escape decode and key classification
  always_comb begin
    mode_d = mode_q;
    num_d  = num_q;
    mod_d  = mod_q;
    has_op = 1'b0;
    op     = OP_INSERT;
    unique case (mode_q)
      ESC_SEEN: begin
        priority if (key_byte_i == CH_LBRACKET) begin
          mode_d = ESC_CSI;
          num_d  = '0;
          mod_d  = 1'b0;
        end else if (key_byte_i == CH_O) begin
          mode_d = ESC_SS3;
        end else begin
          mode_d = ESC_PLAIN;
        end
      end
      ESC_CSI, ESC_CSI_MOD: begin
        priority if (key_byte_i >= CH_0 && key_byte_i <= CH_9) begin
          num_d = (num_next > 12'(NUM_SAT)) ? NUM_SAT : num_next[7:0];
        end else if (key_byte_i == CH_SEMI) begin
          mode_d = ESC_CSI_MOD;
          mod_d  = 1'b1;
          num_d  = '0;
        end else begin
          mode_d = ESC_PLAIN;
          priority if (key_byte_i == CH_A || key_byte_i == CH_B) begin
            has_op = !mod_q;
            op     = (key_byte_i == CH_A) ? OP_HOME : OP_END;
          end else if (key_byte_i == CH_C) begin
            has_op = 1'b1;
            op     = mod_q ? OP_WRIGHT : OP_RIGHT;
          end else if (key_byte_i == CH_D) begin
            has_op = 1'b1;
            op     = mod_q ? OP_WLEFT : OP_LEFT;
          end else if (key_byte_i == CH_TILDE && !mod_q) begin
            priority if (num_q == 8'd1) begin
              has_op = 1'b1;
              op     = OP_HOME;
            end else if (num_q == 8'd3) begin
              has_op = 1'b1;
              op     = OP_DELETE;
            end else if (num_q == 8'd4) begin
              has_op = 1'b1;
              op     = OP_END;
            end else begin
              has_op = 1'b0;
            end
          end else begin
            has_op = 1'b0;
          end
        end
      end
      ESC_SS3: begin
        mode_d = ESC_PLAIN;
        if (key_byte_i == CH_F) begin
          has_op = 1'b1;
          op     = OP_END;
        end else if (key_byte_i == CH_H) begin
          has_op = 1'b1;
          op     = OP_HOME;
        end
      end
      default: begin
        mode_d = ESC_PLAIN;
        priority if (key_byte_i == BYTE_ESC) begin
          mode_d = ESC_SEEN;
        end else if (key_byte_i == BYTE_BS || key_byte_i == BYTE_DEL) begin
          has_op = 1'b1;
          op     = OP_BKSP;
        end else if (key_byte_i == BYTE_CR || key_byte_i == BYTE_LF) begin
          has_op = 1'b1;
          op     = OP_ENTER;
        end else if (key_byte_i == BYTE_CTRLC) begin
          has_op = 1'b1;
          op     = OP_CANCEL;
        end else begin
          has_op = 1'b1;
          op     = OP_INSERT;
        end
      end
    endcase
  end

  assign q_push_o   = accept && has_op;
  assign q_cmd_o.op = op;
  assign q_cmd_o.ch = key_byte_i;

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ESC_PLAIN;
      num_q  <= '0;
      mod_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      num_q  <= num_d;
      mod_q  <= mod_d;
    end
  end

endmodule

FILE: hw/rtl/tle_queue.sv
// ---------------------------------------------------------------------------
// Terminal line editor - command queue
// Short FIFO between the front decoder and the edit engine.
// ---------------------------------------------------------------------------
module tle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tle_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output tle_pkg::cmd_t cmd_o
);
  import tle_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

endmodule

FILE: hw/rtl/tle_back.sv
// ---------------------------------------------------------------------------
// Terminal line editor - edit engine
// Runs edit commands against the line store and produces result transfers.
// ---------------------------------------------------------------------------
module tle_back #(
  parameter int unsigned LINE_CAPACITY = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [3:0]    max_chars_i,
  input  logic          q_valid_i,
  input  tle_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [1:0]    out_kind_o,
  output logic [7:0]    out_byte_o,
  output logic [3:0]    line_length_o,
  output logic          last_o
);
  import tle_pkg::*;

  localparam int unsigned IW = $clog2(LINE_CAPACITY);
  localparam logic [IW-1:0] CAP_LIMIT = IW'(LINE_CAPACITY - 1);

  logic [7:0]    store_q [LINE_CAPACITY];
  logic          busy_q;
  op_e           op_q;
  logic [7:0]    ch_q;
  phase_e        ph_q, ph_d;
  logic [IW-1:0] pos_q, pos_d, len_q, len_d, i_q, i_d;
  logic          first_q, first_d, nsp_q, nsp_d;
  logic          pend_valid_q;
  res_t          pend_q, out_q;
  logic          outv_q, last_q;

  logic          step, gen, done, we, full;
  res_t          gen_res;
  logic [IW-1:0] raddr, waddr;
  logic [7:0]    rdata, wdata;

  assign q_pop_o = !busy_q && q_valid_i;
  assign step    = busy_q && (!outv_q || !out_stall_i);
  assign rdata   = store_q[raddr];
  assign full    = (5'(len_q) >= 5'(max_chars_i)) || (len_q >= CAP_LIMIT);

  // command sequencer, one line-store access per cycle while the output is not stalled
  always_comb begin
    ph_d    = ph_q;
    pos_d   = pos_q;
    len_d   = len_q;
    i_d     = i_q;
    first_d = first_q;
    nsp_d   = nsp_q;
    raddr   = i_q;
    gen     = 1'b0;
    gen_res = '{kind: KIND_ECHO, data: 8'h00, len: 4'h0};
    done    = 1'b0;
    we      = 1'b0;
    waddr   = i_q;
    wdata   = rdata;
    unique case (ph_q)
      PH_START: begin
        unique case (op_q)
          OP_INSERT: begin
            if (full) begin
              gen          = 1'b1;
              gen_res.data = BYTE_BEL;
              ph_d         = PH_DONE;
            end else begin
              i_d  = len_q;
              ph_d = PH_SHIFT;
            end
          end
          OP_RIGHT: begin
            gen  = 1'b1;
            ph_d = PH_DONE;
            if (pos_q < len_q) begin
              raddr        = pos_q;
              gen_res.data = rdata;
              pos_d        = pos_q + 1'b1;
            end else begin
              gen_res.data = BYTE_BEL;
            end
          end
          OP_LEFT: begin
            gen  = 1'b1;
            ph_d = PH_DONE;
            if (pos_q != '0) begin
              gen_res.data = BYTE_BS;
              pos_d        = pos_q - 1'b1;
            end else begin
              gen_res.data = BYTE_BEL;
            end
          end
          OP_WRIGHT, OP_WLEFT: begin
            first_d = 1'b1;
            ph_d    = PH_WORD;
          end
          OP_HOME: begin
            if (pos_q != '0) begin
              gen          = 1'b1;
              gen_res.data = BYTE_BS;
              pos_d        = pos_q - 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          OP_END: begin
            if (pos_q < len_q) begin
              raddr        = pos_q;
              gen          = 1'b1;
              gen_res.data = rdata;
              pos_d        = pos_q + 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          OP_BKSP: begin
            gen = 1'b1;
            priority if (pos_q == '0) begin
              gen_res.data = BYTE_BEL;
              ph_d         = PH_DONE;
            end else if (len_q == pos_q) begin
              gen_res.data = BYTE_BS;
              pos_d        = pos_q - 1'b1;
              len_d        = len_q - 1'b1;
              ph_d         = PH_RUB1;
            end else begin
              gen_res.data = BYTE_BS;
              pos_d        = pos_q - 1'b1;
              ph_d         = PH_DEL;
            end
          end
          OP_DELETE: ph_d = PH_DEL;
          OP_ENTER: begin
            gen          = 1'b1;
            gen_res.data = BYTE_CR;
            ph_d         = PH_LF;
          end
          OP_CANCEL: begin
            gen          = 1'b1;
            gen_res.data = CH_CARET;
            ph_d         = PH_CEE;
          end
          default: done = 1'b1;
        endcase
      end
      // open a gap at the cursor, then place the character
      PH_SHIFT: begin
        we = 1'b1;
        if (i_q > pos_q) begin
          raddr = i_q - 1'b1;
          waddr = i_q;
          wdata = rdata;
          i_d   = i_q - 1'b1;
        end else begin
          waddr = pos_q;
          wdata = ch_q;
          len_d = len_q + 1'b1;
          i_d   = pos_q;
          ph_d  = PH_ECHO;
        end
      end
      PH_ECHO: begin
        if (i_q < len_q) begin
          raddr        = i_q;
          gen          = 1'b1;
          gen_res.data = rdata;
          i_d          = i_q + 1'b1;
        end else begin
          pos_d = pos_q + 1'b1;
          i_d   = len_q;
          ph_d  = PH_BACK;
        end
      end
      // walk the terminal cursor back to the edit point
      PH_BACK: begin
        if (i_q > pos_q) begin
          gen          = 1'b1;
          gen_res.data = BYTE_BS;
          i_d          = i_q - 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      // word moves keep the previous character's class in nsp_q
      PH_WORD: begin
        if (op_q == OP_WRIGHT) begin
          raddr = pos_q;
          if (pos_q >= len_q) begin
            done = 1'b1;
          end else if (!first_q && nsp_q && rdata == BYTE_SP) begin
            done = 1'b1;
          end else begin
            gen          = 1'b1;
            gen_res.data = rdata;
            pos_d        = pos_q + 1'b1;
            nsp_d        = (rdata != BYTE_SP);
            first_d      = 1'b0;
          end
        end else begin
          raddr = pos_q - 1'b1;
          if (pos_q == '0) begin
            done = 1'b1;
          end else if (!first_q && nsp_q && rdata == BYTE_SP) begin
            done = 1'b1;
          end else begin
            gen          = 1'b1;
            gen_res.data = BYTE_BS;
            pos_d        = pos_q - 1'b1;
            nsp_d        = (rdata != BYTE_SP);
            first_d      = 1'b0;
          end
        end
      end
      PH_DEL: begin
        if (len_q <= pos_q) begin
          done = 1'b1;
        end else begin
          len_d = len_q - 1'b1;
          i_d   = pos_q;
          ph_d  = PH_DSHIFT;
        end
      end
      // close the gap and blank the freed tail entry
      PH_DSHIFT: begin
        we = 1'b1;
        if (i_q < len_q) begin
          raddr = i_q + 1'b1;
          waddr = i_q;
          wdata = rdata;
          i_d   = i_q + 1'b1;
        end else begin
          waddr = i_q;
          wdata = BYTE_SP;
          i_d   = pos_q;
          ph_d  = PH_DECHO;
        end
      end
      PH_DECHO: begin
        if (i_q <= len_q) begin
          raddr        = i_q;
          gen          = 1'b1;
          gen_res.data = rdata;
          i_d          = i_q + 1'b1;
        end else begin
          ph_d = PH_BACK;
        end
      end
      PH_RUB1: begin
        gen          = 1'b1;
        gen_res.data = BYTE_SP;
        ph_d         = PH_RUB2;
      end
      PH_RUB2: begin
        gen          = 1'b1;
        gen_res.data = BYTE_BS;
        ph_d         = PH_DONE;
      end
      PH_LF: begin
        gen          = 1'b1;
        gen_res.data = BYTE_LF;
        i_d          = '0;
        ph_d         = PH_LINE;
      end
      // hand out the line, then the finish marker
      PH_LINE: begin
        gen = 1'b1;
        if (i_q < len_q) begin
          raddr        = i_q;
          gen_res.kind = KIND_LINE;
          gen_res.data = rdata;
          i_d          = i_q + 1'b1;
        end else begin
          gen_res.kind = KIND_FINISH;
          gen_res.len  = 4'(len_q);
          pos_d        = '0;
          len_d        = '0;
          ph_d         = PH_DONE;
        end
      end
      PH_CEE: begin
        gen          = 1'b1;
        gen_res.data = CH_C;
        ph_d         = PH_CANCEL;
      end
      PH_CANCEL: begin
        gen          = 1'b1;
        gen_res.kind = KIND_CANCEL;
        pos_d        = '0;
        len_d        = '0;
        ph_d         = PH_DONE;
      end
      default: done = 1'b1;
    endcase
  end

  // sequencer and edit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      op_q    <= OP_INSERT;
      ch_q    <= '0;
      ph_q    <= PH_START;
      pos_q   <= '0;
      len_q   <= '0;
      i_q     <= '0;
      first_q <= 1'b0;
      nsp_q   <= 1'b0;
    end else if (q_pop_o) begin
      busy_q <= 1'b1;
      op_q   <= q_cmd_i.op;
      ch_q   <= q_cmd_i.ch;
      ph_q   <= PH_START;
    end else if (step) begin
      busy_q  <= !done;
      ph_q    <= ph_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      i_q     <= i_d;
      first_q <= first_d;
      nsp_q   <= nsp_d;
    end
  end

  // one result held back so the final one can be flagged
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      outv_q       <= 1'b0;
      last_q       <= 1'b0;
    end else begin
      if (step && pend_valid_q && (gen || done)) begin
        outv_q <= 1'b1;
        last_q <= done;
      end else if (outv_q && !out_stall_i) begin
        outv_q <= 1'b0;
      end
      if (step && gen) begin
        pend_valid_q <= 1'b1;
      end else if (step && done) begin
        pend_valid_q <= 1'b0;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk_i) begin
    if (step && pend_valid_q && (gen || done)) out_q <= pend_q;
    if (step && gen) pend_q <= gen_res;
  end

  // line store
  always_ff @(posedge clk_i) begin
    if (step && we) store_q[waddr] <= wdata;
  end

  assign out_valid_o   = outv_q;
  assign out_kind_o    = out_q.kind;
  assign out_byte_o    = out_q.data;
  assign line_length_o = out_q.len;
  assign last_o        = last_q;

endmodule

FILE: hw/rtl/tle_checker.sv
// ---------------------------------------------------------------------------
// Terminal line editor - port checker
// Watches the top-level result channel and checks its field rules.
// ---------------------------------------------------------------------------
`include "terminal_line_editor_unit_defines.svh"

module tle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic [3:0] line_length_o,
  input logic       last_o
);
  import tle_pkg::*;

  // a stalled result transfer keeps its payload
  `TLE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_kind_o) && $stable(last_o), "stalled result changed")

  // finish and cancel carry no byte
  `TLE_ASSERT(a_mark_zero, out_valid_o && (out_kind_o == KIND_FINISH || out_kind_o == KIND_CANCEL) |-> out_byte_o == 8'h00, "finish or cancel with nonzero byte")

  // length only shows on a finish
  `TLE_ASSERT(a_len_finish, out_valid_o && out_kind_o != KIND_FINISH |-> line_length_o == 4'h0, "line length outside finish")

  // finish and cancel close the byte's results
  `TLE_ASSERT_ALWAYS(a_mark_last, rst_ni && out_valid_o && (out_kind_o == KIND_FINISH || out_kind_o == KIND_CANCEL) |-> last_o, "finish or cancel not last")

endmodule

bind terminal_line_editor_unit tle_checker u_tle_checker (.*);
